// ===== hw/rtl/bcre_pkg.sv =====
// shared constants, codes and table function for the relative permeability evaluator
package bcre_pkg;

	// default fraction width of saturations and permeabilities
	localparam int FRAC_BITS_DEF = 16;
	// exponent fraction bits (Q4.12) and log fraction bits
	localparam int EXP_FRAC = 12;
	localparam int LOG_FRAC = 28;
	localparam int EXP_W = 16;

	localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;
	localparam logic [15:0] EXP_ONE = 16'h1000;
	localparam logic [31:0] SLOPE_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SLOPE_MIN = 32'h8000_0000;

	// region codes
	localparam logic [1:0] REG_BELOW = 2'd0;
	localparam logic [1:0] REG_ABOVE = 2'd1;
	localparam logic [1:0] REG_POWER = 2'd2;

	// how a slope is formed at the end
	typedef enum logic [1:0] {
		SL_DIV  = 2'd0,
		SL_ZERO = 2'd1,
		SL_EXT  = 2'd2
	} slope_mode_t;

	// c_k = 2^(-2^-k) in Q32, c_0 = 1/2, each the floor square root of the last
	function automatic logic [31:0] exp_const(input int k);
		logic [63:0] c;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bv;
		c = 64'h8000_0000;
		for (int j = 1; j <= k; j++) begin
			v = c << 32;
			res = 64'd0;
			bv = 64'd1 << 62;
			for (int n = 0; n < 32; n++) begin
				if (v >= res + bv) begin
					v = v - (res + bv);
					res = (res >> 1) + bv;
				end else begin
					res = res >> 1;
				end
				bv = bv >> 2;
			end
			c = res;
		end
		return c[31:0];
	endfunction

endpackage

// ===== hw/rtl/brooks_corey_relperm_eval.sv =====
// top level: region split, ratio dividers, power units, permeabilities and slope dividers
// from start to done a request passes the two bit-per-stage divider pipelines
// and the two 28-step log and exp chains
// throughput one request per cycle; busy stays low, every stage advances every cycle
// asynchronous active-low reset clears all valid bits; payload registers are not reset
module brooks_corey_relperm_eval import bcre_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [FRAC_BITS:0]   saturation,
	input  logic [FRAC_BITS:0]   irreducible_sat,
	input  logic [FRAC_BITS:0]   residual_sat,
	input  logic [EXP_W-1:0]     exponent_first,
	input  logic [EXP_W-1:0]     exponent_other,
	input  logic [FRAC_BITS:0]   endpoint_first,
	input  logic [FRAC_BITS:0]   endpoint_other,
	output logic                 done,
	output logic [FRAC_BITS:0]   perm_first,
	output logic [FRAC_BITS:0]   perm_other,
	output logic signed [31:0]   slope_first,
	output logic signed [31:0]   slope_other,
	output logic [1:0]           region
);

	localparam int W = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};
	localparam int PW = 2 * W;
	localparam int NUM_W = EXP_W + W;
	localparam int SNW = NUM_W + FRAC_BITS;
	localparam int SDW = W + EXP_FRAC;

	typedef struct packed {
		logic [EXP_W-1:0] m;
		logic [W-1:0]     k;
		logic [W-1:0]     num;
	} first_side_t;

	typedef struct packed {
		logic [EXP_W-1:0] m;
		logic [W-1:0]     k;
		logic [W-1:0]     num;
		logic [W-1:0]     den;
		logic [1:0]       reg_code;
		logic             dz;
	} other_side_t;

	typedef struct packed {
		slope_mode_t  mode;
		logic [W-1:0] perm;
	} sl_first_t;

	typedef struct packed {
		slope_mode_t  mode;
		logic [W-1:0] perm;
		logic [1:0]   reg_code;
	} sl_other_t;

	typedef struct packed {
		slope_mode_t  mode;
		logic [W-1:0] k;
		logic [W-1:0] d;
	} prep_t;

	// slope operands for one phase
	function automatic prep_t pick(input logic both_nz, input logic own_nz,
		input logic [EXP_W-1:0] m, input logic [W-1:0] k, input logic [W-1:0] kmax,
		input logic [W-1:0] own, input logic [W-1:0] den);
		prep_t pr;
		pr.mode = SL_DIV;
		pr.k = k;
		pr.d = own;
		if (!both_nz) begin
			pr.k = kmax;
			pr.d = den;
			if ((m == '0) || (kmax == '0)) begin
				pr.mode = SL_ZERO;
			end else if (own_nz || (m == EXP_ONE)) begin
				pr.mode = SL_DIV;
			end else if (m > EXP_ONE) begin
				pr.mode = SL_ZERO;
			end else begin
				pr.mode = SL_EXT;
			end
		end
		if (pr.mode == SL_DIV) begin
			if ((m == '0) || (pr.k == '0)) begin
				pr.mode = SL_ZERO;
			end else if (pr.d == '0) begin
				pr.mode = SL_EXT;
			end
		end
		return pr;
	endfunction

	assign busy = 1'b0;

	// region split and differences
	logic         below;
	logic         above;
	logic [W:0]   s_sum;
	logic [1:0]   reg_code;
	logic [W-1:0] den_w;

	assign s_sum = {1'b0, saturation} + {1'b0, residual_sat};
	assign below = saturation < irreducible_sat;
	assign above = s_sum > {1'b0, ONE_W};
	assign reg_code = below ? REG_BELOW : (above ? REG_ABOVE : REG_POWER);
	assign den_w = ONE_W - irreducible_sat - residual_sat;

	logic        vld_s1;
	first_side_t fs_s1;
	other_side_t os_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		fs_s1.m        <= exponent_first;
		fs_s1.k        <= endpoint_first;
		fs_s1.num      <= saturation - irreducible_sat;
		os_s1.m        <= exponent_other;
		os_s1.k        <= endpoint_other;
		os_s1.num      <= ONE_W - saturation - residual_sat;
		os_s1.den      <= den_w;
		os_s1.reg_code <= reg_code;
		os_s1.dz       <= (reg_code == REG_POWER) && (den_w == '0);
	end

	// normalized saturation ratios in Q32
	logic                       rv1;
	logic                       rv2;
	logic [32:0]                rq1;
	logic [32:0]                rq2;
	logic                       ro1;
	logic                       ro2;
	logic [$bits(first_side_t)-1:0] rs1;
	logic [$bits(other_side_t)-1:0] rs2;

	bcre_div #(.NW(W + 32), .DW(W), .QW(33), .SW($bits(first_side_t))) u_rdiv1 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1),
		.in_num({fs_s1.num, 32'd0}), .in_den(os_s1.den), .in_side(fs_s1),
		.out_vld(rv1), .out_quo(rq1), .out_ovf(ro1), .out_side(rs1)
	);

	bcre_div #(.NW(W + 32), .DW(W), .QW(33), .SW($bits(other_side_t))) u_rdiv2 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1),
		.in_num({os_s1.num, 32'd0}), .in_den(os_s1.den), .in_side(os_s1),
		.out_vld(rv2), .out_quo(rq2), .out_ovf(ro2), .out_side(rs2)
	);

	first_side_t rfs;
	other_side_t ros;
	assign rfs = rs1;
	assign ros = rs2;

	// powers of the ratios
	logic                       pv1;
	logic                       pv2;
	logic [32:0]                pw1;
	logic [32:0]                pw2;
	logic [$bits(first_side_t)-1:0] ps1;
	logic [$bits(other_side_t)-1:0] ps2;

	bcre_pow #(.SW($bits(first_side_t))) u_pow1 (
		.clk(clk), .arst_n(arst_n), .in_vld(rv1 & rv2),
		.in_r(ro1 ? Q32_ONE : rq1), .in_m(rfs.m), .in_side(rs1),
		.out_vld(pv1), .out_pw(pw1), .out_side(ps1)
	);

	bcre_pow #(.SW($bits(other_side_t))) u_pow2 (
		.clk(clk), .arst_n(arst_n), .in_vld(rv1 & rv2),
		.in_r(ro2 ? Q32_ONE : rq2), .in_m(ros.m), .in_side(rs2),
		.out_vld(pv2), .out_pw(pw2), .out_side(ps2)
	);

	// round powers to the output fraction width
	logic [33:0] pr1;
	logic [33:0] pr2;
	assign pr1 = {1'b0, pw1} + (34'd1 << (31 - FRAC_BITS));
	assign pr2 = {1'b0, pw2} + (34'd1 << (31 - FRAC_BITS));

	logic         vld_s2;
	logic [W-1:0] p1_s2;
	logic [W-1:0] p2_s2;
	first_side_t  fs_s2;
	other_side_t  os_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= pv1 & pv2;
		end
	end

	always_ff @(posedge clk) begin
		p1_s2 <= W'(pr1 >> (32 - FRAC_BITS));
		p2_s2 <= W'(pr2 >> (32 - FRAC_BITS));
		fs_s2 <= ps1;
		os_s2 <= ps2;
	end

	// scale by the end points
	logic [PW-1:0] kp1;
	logic [PW-1:0] kp2;
	assign kp1 = PW'(fs_s2.k) * PW'(p1_s2) + (PW'(1) << (FRAC_BITS - 1));
	assign kp2 = PW'(os_s2.k) * PW'(p2_s2) + (PW'(1) << (FRAC_BITS - 1));

	logic         vld_s3;
	logic [W-1:0] k1_s3;
	logic [W-1:0] k2_s3;
	first_side_t  fs_s3;
	other_side_t  os_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		k1_s3 <= W'(kp1 >> FRAC_BITS);
		k2_s3 <= W'(kp2 >> FRAC_BITS);
		fs_s3 <= fs_s2;
		os_s3 <= os_s2;
	end

	// slope operands, special cases and final permeabilities
	logic  both_nz;
	prep_t pk1;
	prep_t pk2;
	slope_mode_t md1;
	slope_mode_t md2;
	logic [W-1:0] fk1;
	logic [W-1:0] fk2;

	assign both_nz = (fs_s3.num != '0) && (os_s3.num != '0);
	assign pk1 = pick(both_nz, fs_s3.num != '0, fs_s3.m, k1_s3, fs_s3.k, fs_s3.num,
		os_s3.den);
	assign pk2 = pick(both_nz, os_s3.num != '0, os_s3.m, k2_s3, os_s3.k, os_s3.num,
		os_s3.den);

	always_comb begin
		md1 = pk1.mode;
		md2 = pk2.mode;
		fk1 = k1_s3;
		fk2 = k2_s3;
		if (os_s3.reg_code == REG_BELOW) begin
			md1 = SL_ZERO;
			md2 = SL_ZERO;
			fk1 = W'(1);
			fk2 = os_s3.k;
		end else if (os_s3.reg_code == REG_ABOVE) begin
			md1 = SL_ZERO;
			md2 = SL_ZERO;
			fk1 = fs_s3.k;
			fk2 = W'(1);
		end else if (os_s3.dz) begin
			md1 = ((fs_s3.m != '0) && (fs_s3.k != '0)) ? SL_EXT : SL_ZERO;
			md2 = ((os_s3.m != '0) && (os_s3.k != '0)) ? SL_EXT : SL_ZERO;
			fk1 = fs_s3.k;
			fk2 = os_s3.k;
		end
	end

	logic             vld_s4;
	logic [NUM_W-1:0] n1_s4;
	logic [NUM_W-1:0] n2_s4;
	logic [W-1:0]     d1_s4;
	logic [W-1:0]     d2_s4;
	sl_first_t        sf_s4;
	sl_other_t        so_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		n1_s4 <= NUM_W'(fs_s3.m) * NUM_W'(pk1.k);
		n2_s4 <= NUM_W'(os_s3.m) * NUM_W'(pk2.k);
		d1_s4 <= pk1.d;
		d2_s4 <= pk2.d;
		sf_s4.mode <= md1;
		sf_s4.perm <= fk1;
		so_s4.mode <= md2;
		so_s4.perm <= fk2;
		so_s4.reg_code <= os_s3.reg_code;
	end

	// slope quotients
	logic                         sv1;
	logic                         sv2;
	logic [31:0]                  sq1;
	logic [31:0]                  sq2;
	logic                         so1;
	logic                         so2;
	logic [$bits(sl_first_t)-1:0] ss1;
	logic [$bits(sl_other_t)-1:0] ss2;

	bcre_div #(.NW(SNW), .DW(SDW), .QW(32), .SW($bits(sl_first_t))) u_sdiv1 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s4),
		.in_num({n1_s4, {FRAC_BITS{1'b0}}}), .in_den({d1_s4, {EXP_FRAC{1'b0}}}),
		.in_side(sf_s4),
		.out_vld(sv1), .out_quo(sq1), .out_ovf(so1), .out_side(ss1)
	);

	bcre_div #(.NW(SNW), .DW(SDW), .QW(32), .SW($bits(sl_other_t))) u_sdiv2 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s4),
		.in_num({n2_s4, {FRAC_BITS{1'b0}}}), .in_den({d2_s4, {EXP_FRAC{1'b0}}}),
		.in_side(so_s4),
		.out_vld(sv2), .out_quo(sq2), .out_ovf(so2), .out_side(ss2)
	);

	sl_first_t sf;
	sl_other_t so;
	assign sf = ss1;
	assign so = ss2;

	// saturation and sign of the slopes
	logic [31:0] sl1;
	logic [31:0] sl2;

	always_comb begin
		case (sf.mode)
			SL_DIV:  sl1 = (so1 || sq1[31]) ? SLOPE_MAX : sq1;
			SL_EXT:  sl1 = SLOPE_MAX;
			default: sl1 = '0;
		endcase
		case (so.mode)
			SL_DIV:  sl2 = (so2 || sq2[31]) ? SLOPE_MIN : (32'd0 - sq2);
			SL_EXT:  sl2 = SLOPE_MIN;
			default: sl2 = '0;
		endcase
	end

	logic         vld_s5;
	logic [W-1:0] k1_s5;
	logic [W-1:0] k2_s5;
	logic [31:0]  sl1_s5;
	logic [31:0]  sl2_s5;
	logic [1:0]   reg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= sv1 & sv2;
		end
	end

	always_ff @(posedge clk) begin
		k1_s5  <= sf.perm;
		k2_s5  <= so.perm;
		sl1_s5 <= sl1;
		sl2_s5 <= sl2;
		reg_s5 <= so.reg_code;
	end

	assign done        = vld_s5;
	assign perm_first  = k1_s5;
	assign perm_other  = k2_s5;
	assign slope_first = sl1_s5;
	assign slope_other = sl2_s5;
	assign region      = reg_s5;

endmodule

// ===== hw/rtl/bcre_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
module bcre_div import bcre_pkg::*; #(
	parameter int NW = 49,
	parameter int DW = 17,
	parameter int QW = 33,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [QW-1:0] out_quo,
	output logic          out_ovf,
	output logic [SW-1:0] out_side
);

	logic          dv_s [0:NW];
	logic [NW-1:0] dw_s [0:NW];
	logic [DW-1:0] dr_s [0:NW];
	logic [DW-1:0] dd_s [0:NW];
	logic          do_s [0:NW];
	logic [SW-1:0] ds_s [0:NW];

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else begin
			dv_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		dw_s[0] <= in_num;
		dr_s[0] <= '0;
		dd_s[0] <= in_den;
		do_s[0] <= 1'b0;
		ds_s[0] <= in_side;
	end

	// one shift, compare and subtract per stage
	for (genvar i = 0; i < NW; i++) begin : g_step
		localparam bit HIGH_BIT = (i < NW - QW);
		logic [DW:0]   r2;
		logic          ge;
		logic [DW:0]   rn;

		assign r2 = {dr_s[i], dw_s[i][NW-1]};
		assign ge = r2 >= {1'b0, dd_s[i]};
		assign rn = ge ? (r2 - {1'b0, dd_s[i]}) : r2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[i+1] <= 1'b0;
			end else begin
				dv_s[i+1] <= dv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			dr_s[i+1] <= rn[DW-1:0];
			dw_s[i+1] <= {dw_s[i][NW-2:0], ge};
			dd_s[i+1] <= dd_s[i];
			do_s[i+1] <= do_s[i] | (ge & HIGH_BIT);
			ds_s[i+1] <= ds_s[i];
		end
	end

	assign out_vld  = dv_s[NW];
	assign out_quo  = dw_s[NW][QW-1:0];
	assign out_ovf  = do_s[NW];
	assign out_side = ds_s[NW];

endmodule

// ===== hw/rtl/bcre_pow.sv =====
// pipelined Q32 power r^m through a squaring log and a constant product exp
module bcre_pow import bcre_pkg::*; #(
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [32:0]      in_r,
	input  logic [EXP_W-1:0] in_m,
	input  logic [SW-1:0]    in_side,
	output logic             out_vld,
	output logic [32:0]      out_pw,
	output logic [SW-1:0]    out_side
);

	typedef struct packed {
		logic             one;
		logic             zero;
		logic [4:0]       p;
		logic [EXP_W-1:0] m;
	} pw_ctl_t;

	// leading one search
	logic [4:0] lead;
	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (in_r[i]) begin
				lead = 5'(i);
			end
		end
	end

	logic          vld_s1;
	logic [31:0]   r_s1;
	pw_ctl_t       ctl_s1;
	logic [SW-1:0] side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		r_s1        <= in_r[31:0];
		ctl_s1.one  <= (in_m == '0) || in_r[32];
		ctl_s1.zero <= (in_m != '0) && (in_r == '0);
		ctl_s1.p    <= lead;
		ctl_s1.m    <= in_m;
		side_s1     <= in_side;
	end

	// log chain: index 0 holds the normalized mantissa
	logic                lv_s [0:LOG_FRAC];
	logic [31:0]         lm_s [0:LOG_FRAC];
	logic [LOG_FRAC-1:0] lf_s [0:LOG_FRAC];
	pw_ctl_t             lc_s [0:LOG_FRAC];
	logic [SW-1:0]       ls_s [0:LOG_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_s[0] <= 1'b0;
		end else begin
			lv_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		lm_s[0] <= r_s1 << (5'd31 - ctl_s1.p);
		lf_s[0] <= '0;
		lc_s[0] <= ctl_s1;
		ls_s[0] <= side_s1;
	end

	// one squaring per stage gives one fraction bit of log2
	for (genvar i = 0; i < LOG_FRAC; i++) begin : g_log
		logic [63:0] sq;
		logic [32:0] t;

		assign sq = 64'(lm_s[i]) * 64'(lm_s[i]);
		assign t  = sq[63:31];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lv_s[i+1] <= 1'b0;
			end else begin
				lv_s[i+1] <= lv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			lm_s[i+1] <= t[32] ? t[32:1] : t[31:0];
			lf_s[i+1] <= {lf_s[i][LOG_FRAC-2:0], t[32]};
			lc_s[i+1] <= lc_s[i];
			ls_s[i+1] <= ls_s[i];
		end
	end

	// negative log with integer part
	logic          vld_s3;
	logic [33:0]   nl_s3;
	pw_ctl_t       ctl_s3;
	logic [SW-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= lv_s[LOG_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		nl_s3   <= {6'd32 - {1'b0, lc_s[LOG_FRAC].p}, 28'd0} - 34'(lf_s[LOG_FRAC]);
		ctl_s3  <= lc_s[LOG_FRAC];
		side_s3 <= ls_s[LOG_FRAC];
	end

	// scale by the exponent
	logic [49:0] prod;
	assign prod = 50'(ctl_s3.m) * 50'(nl_s3);

	logic                ev_s [0:LOG_FRAC];
	logic [32:0]         er_s [0:LOG_FRAC];
	logic [LOG_FRAC-1:0] ef_s [0:LOG_FRAC];
	logic [9:0]          ei_s [0:LOG_FRAC];
	pw_ctl_t             ec_s [0:LOG_FRAC];
	logic [SW-1:0]       es_s [0:LOG_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s[0] <= 1'b0;
		end else begin
			ev_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		er_s[0] <= Q32_ONE;
		ef_s[0] <= prod[39:12];
		ei_s[0] <= prod[49:40];
		ec_s[0] <= ctl_s3;
		es_s[0] <= side_s3;
	end

	// exp chain: one constant factor per fraction bit
	for (genvar j = 0; j < LOG_FRAC; j++) begin : g_exp
		localparam logic [31:0] CK = exp_const(j + 1);
		logic [64:0] pr;

		assign pr = 65'(er_s[j]) * 65'(CK);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ev_s[j+1] <= 1'b0;
			end else begin
				ev_s[j+1] <= ev_s[j];
			end
		end

		always_ff @(posedge clk) begin
			er_s[j+1] <= ef_s[j][LOG_FRAC-1-j] ? pr[64:32] : er_s[j];
			ef_s[j+1] <= ef_s[j];
			ei_s[j+1] <= ei_s[j];
			ec_s[j+1] <= ec_s[j];
			es_s[j+1] <= es_s[j];
		end
	end

	// integer shift and special cases
	logic          vld_s5;
	logic [32:0]   pw_s5;
	logic [SW-1:0] side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= ev_s[LOG_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		if (ec_s[LOG_FRAC].one) begin
			pw_s5 <= Q32_ONE;
		end else if (ec_s[LOG_FRAC].zero || (ei_s[LOG_FRAC] >= 10'd33)) begin
			pw_s5 <= '0;
		end else begin
			pw_s5 <= er_s[LOG_FRAC] >> ei_s[LOG_FRAC][5:0];
		end
		side_s5 <= es_s[LOG_FRAC];
	end

	assign out_vld  = vld_s5;
	assign out_pw   = pw_s5;
	assign out_side = side_s5;

endmodule

// ===== test/tb_top.sv =====
// testbench for the relative permeability evaluator: random and directed cells with a scoreboard
`timescale 1ns / 1ps

module tb_top import bcre_pkg::*;;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint unsigned ONE = 64'd1 << FB;
	localparam int LATENCY = 3 * FB + 118;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		bit [63:0] sat, scr, sor, mc, mo, kc, ko;
	} cell_t;

	typedef struct packed {
		bit [16:0] k1, k2;
		bit [31:0] d1, d2;
		bit [1:0]  reg_code;
	} perm_t;

	// relative permeability predictor and store of expected results
	class relperm_scoreboard;
		perm_t     pending[$];
		bit [63:0] exp_c[LOG_FRAC+1];
		int        errors;

		function new();
			bit [63:0] v, res, bv;
			exp_c[0] = 64'h8000_0000;
			for (int k = 1; k <= LOG_FRAC; k++) begin
				v = exp_c[k-1] << 32;
				res = 0;
				bv = 64'd1 << 62;
				while (bv > v) bv = bv >> 2;
				while (bv != 0) begin
					if (v >= res + bv) begin
						v = v - (res + bv);
						res = (res >> 1) + bv;
					end else begin
						res = res >> 1;
					end
					bv = bv >> 2;
				end
				exp_c[k] = res;
			end
			errors = 0;
		endfunction

		// r^m, r in Q32, m in Q4.12, via base-2 log and antilog
		function bit [63:0] power_q32(bit [63:0] r, bit [63:0] m);
			bit [63:0] mant, frac, nl, prod, ip, fp, res;
			int p;
			if (m == 0) return 64'd1 << 32;
			if (r == 0) return 0;
			if (r >= (64'd1 << 32)) return 64'd1 << 32;
			p = 31;
			while (r[p] == 1'b0) p--;
			mant = r << (31 - p);
			frac = 0;
			for (int i = 0; i < LOG_FRAC; i++) begin
				mant = (mant * mant) >> 31;
				frac = frac << 1;
				if (mant >= (64'd1 << 32)) begin
					mant = mant >> 1;
					frac = frac | 1;
				end
			end
			nl = (64'(32 - p) << LOG_FRAC) - frac;
			prod = (m * nl) >> EXP_FRAC;
			ip = prod >> LOG_FRAC;
			if (ip >= 33) return 0;
			fp = prod & ((64'd1 << LOG_FRAC) - 1);
			res = 64'd1 << 32;
			for (int k = 1; k <= LOG_FRAC; k++)
				if (fp[LOG_FRAC-k]) res = (res * exp_c[k]) >> 32;
			return res >> ip;
		endfunction

		function bit [63:0] clip_slope(bit [63:0] q, bit neg);
			if (!neg) return (q > 64'(SLOPE_MAX)) ? 64'(SLOPE_MAX) : q;
			if (q >= 64'(SLOPE_MIN)) return 64'(SLOPE_MIN);
			return ((64'd1 << 32) - q) & 64'hFFFF_FFFF;
		endfunction

		function bit [63:0] slope_quot(bit [63:0] m, bit [63:0] k, bit [63:0] d, bit neg);
			bit [63:0] num;
			num = m * k;
			if (num == 0) return 0;
			if (d == 0) return neg ? 64'(SLOPE_MIN) : 64'(SLOPE_MAX);
			return clip_slope((num << FB) / (d << EXP_FRAC), neg);
		endfunction

		// slope when the normalized saturation is exactly 0 or 1
		function bit [63:0] slope_at_end(bit unit, bit [63:0] m, bit [63:0] kmax,
				bit [63:0] den, bit neg);
			if (m == 0 || kmax == 0) return 0;
			if (unit || m == 64'(EXP_ONE)) return slope_quot(m, kmax, den, neg);
			if (m > 64'(EXP_ONE)) return 0;
			return neg ? 64'(SLOPE_MIN) : 64'(SLOPE_MAX);
		endfunction

		function void note_request(cell_t c);
			perm_t e;
			bit [63:0] k1, k2, d1, d2, up, oup, den, p1, p2, q;
			d1 = 0;
			d2 = 0;
			if (c.sat < c.scr) begin
				k1 = 1; k2 = c.ko; e.reg_code = REG_BELOW;
			end else if (c.sat + c.sor > ONE) begin
				k1 = c.kc; k2 = 1; e.reg_code = REG_ABOVE;
			end else begin
				e.reg_code = REG_POWER;
				up = c.sat - c.scr;
				oup = ONE - c.sat - c.sor;
				den = ONE - c.scr - c.sor;
				if (den == 0) begin
					k1 = c.kc; k2 = c.ko;
					d1 = (c.mc * c.kc != 0) ? 64'(SLOPE_MAX) : 0;
					d2 = (c.mo * c.ko != 0) ? 64'(SLOPE_MIN) : 0;
				end else begin
					q = power_q32((up << 32) / den, c.mc);
					p1 = (q + (64'd1 << (31 - FB))) >> (32 - FB);
					q = power_q32((oup << 32) / den, c.mo);
					p2 = (q + (64'd1 << (31 - FB))) >> (32 - FB);
					k1 = (c.kc * p1 + (ONE >> 1)) >> FB;
					k2 = (c.ko * p2 + (ONE >> 1)) >> FB;
					if (up != 0 && oup != 0) begin
						d1 = slope_quot(c.mc, k1, up, 1'b0);
						d2 = slope_quot(c.mo, k2, oup, 1'b1);
					end else begin
						d1 = slope_at_end(up != 0, c.mc, c.kc, den, 1'b0);
						d2 = slope_at_end(oup != 0, c.mo, c.ko, den, 1'b1);
					end
				end
			end
			e.k1 = k1[16:0];
			e.k2 = k2[16:0];
			e.d1 = d1[31:0];
			e.d2 = d2[31:0];
			pending.push_back(e);
		endfunction

		function void check_result(perm_t a);
			perm_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("result with no request pending");
				return;
			end
			e = pending.pop_front();
			if (a != e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp %h %h %h %h %0d got %h %h %h %h %0d",
						e.k1, e.k2, e.d1, e.d2, e.reg_code,
						a.k1, a.k2, a.d1, a.d2, a.reg_code);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	logic [FB:0] saturation, irreducible_sat, residual_sat, endpoint_first, endpoint_other;
	logic [EXP_W-1:0] exponent_first, exponent_other;
	logic [FB:0] perm_first, perm_other;
	logic signed [31:0] slope_first, slope_other;
	logic [1:0] region;

	relperm_scoreboard sb = new();
	int idle_pct;
	int quiet_cycles;

	brooks_corey_relperm_eval uut (.*);

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// note accepted requests and check strobed results
	always @(posedge clk) begin
		cell_t c;
		perm_t r;
		if (arst_n && start && !busy) begin
			c.sat = saturation; c.scr = irreducible_sat; c.sor = residual_sat;
			c.mc = exponent_first; c.mo = exponent_other;
			c.kc = endpoint_first; c.ko = endpoint_other;
			sb.note_request(c);
		end
		if (arst_n && done) begin
			r.k1 = perm_first; r.k2 = perm_other;
			r.d1 = slope_first; r.d2 = slope_other; r.reg_code = region;
			sb.check_result(r);
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > STALL_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// drive one request and wait for it to be taken, then maybe leave a gap
	task automatic send_cell(cell_t c);
		saturation <= c.sat[FB:0];
		irreducible_sat <= c.scr[FB:0];
		residual_sat <= c.sor[FB:0];
		exponent_first <= c.mc[15:0];
		exponent_other <= c.mo[15:0];
		endpoint_first <= c.kc[FB:0];
		endpoint_other <= c.ko[FB:0];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic cell_t make_cell(bit [63:0] s, bit [63:0] scr, bit [63:0] sor,
			bit [63:0] mc, bit [63:0] mo, bit [63:0] kc, bit [63:0] ko);
		cell_t c;
		c.sat = s; c.scr = scr; c.sor = sor; c.mc = mc; c.mo = mo; c.kc = kc; c.ko = ko;
		return c;
	endfunction

	function automatic bit [63:0] rand_exp();
		case ($urandom_range(5))
			0: return $urandom_range(65535);
			1: return 64'(EXP_ONE);
			2: return $urandom_range(0, 4095);
			default: return $urandom_range(4096, 16384);
		endcase
	endfunction

	function automatic bit [63:0] rand_perm();
		case ($urandom_range(7))
			0: return ONE;
			1: return 0;
			default: return $urandom_range(0, ONE);
		endcase
	endfunction

	// random cell, mostly inside the power-law region
	function automatic cell_t rand_cell();
		bit [63:0] scr, sor, s;
		if ($urandom_range(9) < 3) begin
			return make_cell($urandom_range(0, ONE), $urandom_range(0, ONE),
				$urandom_range(0, ONE), $urandom_range(65535), $urandom_range(65535),
				rand_perm(), rand_perm());
		end
		scr = $urandom_range(0, ONE / 2);
		sor = $urandom_range(0, ONE - scr);
		case ($urandom_range(9))
			0: s = scr;
			1: s = ONE - sor;
			default: s = $urandom_range(scr, ONE - sor);
		endcase
		return make_cell(s, scr, sor, rand_exp(), rand_exp(), rand_perm(), rand_perm());
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		saturation = '0; irreducible_sat = '0; residual_sat = '0;
		exponent_first = '0; exponent_other = '0;
		endpoint_first = '0; endpoint_other = '0;
		idle_pct = 10;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cells: regions, zero denominator, end ratios, extremes
		send_cell(make_cell(100, 200, 300, 8192, 8192, 50000, 40000));
		send_cell(make_cell(60000, 100, 10000, 8192, 8192, 50000, 40000));
		send_cell(make_cell(30000, 30000, ONE - 30000, 8192, 8192, 50000, 40000));
		send_cell(make_cell(30000, 30000, ONE - 30000, 0, 8192, 50000, 0));
		send_cell(make_cell(ONE, ONE, 0, 65535, 65535, ONE, ONE));
		send_cell(make_cell(0, 0, ONE, 4096, 4096, ONE, ONE));
		send_cell(make_cell(10000, 10000, 5000, 2048, 2048, 50000, 40000));
		send_cell(make_cell(10000, 10000, 5000, 12288, 12288, 50000, 40000));
		send_cell(make_cell(10000, 10000, 5000, 4096, 4096, 50000, 40000));
		send_cell(make_cell(ONE - 5000, 10000, 5000, 2048, 2048, 50000, 40000));
		send_cell(make_cell(ONE - 5000, 10000, 5000, 12288, 12288, 50000, 40000));
		send_cell(make_cell(30000, 10000, 5000, 0, 0, 50000, 40000));
		send_cell(make_cell(10001, 10000, 5000, 65535, 65535, ONE, ONE));
		send_cell(make_cell(ONE - 5001, 10000, 5000, 65535, 65535, ONE, ONE));
		send_cell(make_cell(30000, 10000, 5000, 8192, 8192, 0, 0));
		send_cell(make_cell(0, 0, 0, 0, 0, 0, 0));
		send_cell(make_cell(ONE, 0, 0, 65535, 65535, ONE, ONE));
		send_cell(make_cell(ONE, ONE, ONE, 65535, 65535, ONE, ONE));
		send_cell(make_cell(1, 0, 0, 1, 1, 1, 1));
		send_cell(make_cell(20000, 0, 0, 32768, 16384, ONE, ONE));

		// hold off until the pipeline has drained
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);

		// random cells in three idling phases
		for (int n = 0; n < 1080; n++) begin
			if (n == 360) idle_pct = 69;
			if (n == 720) idle_pct = 0;
			send_cell(rand_cell());
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
